[hw/rtl/escape_count_palette_assert.svh]
// Assertion macros used by the port-level checker
`ifndef ESCAPE_COUNT_PALETTE_ASSERT_SVH
`define ESCAPE_COUNT_PALETTE_ASSERT_SVH

// Same-cycle implication, reset-gated
`define ECP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, reset-gated
`define ECP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/ecp_pkg.sv]
// Package: shared types and constants of the escape count palette
`timescale 1ns / 1ps
package ecp_pkg;
	localparam int CNT_W  = 16;
	localparam int CH_W   = 8;
	localparam int MODE_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_MODE = 2'd1;

	localparam logic [MODE_W-1:0] MODE_BASIC = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SINE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_GREY  = 2'd2;

	localparam logic [CNT_W-1:0] MAX_COUNT_RST = 16'd100;

	// round(2^32 / (2*pi))
	localparam logic [29:0] PHASE_SCALE = 30'd683565276;
	localparam logic [15:0] SIN_A = 16'd51472;
	localparam logic [14:0] SIN_B = 15'd21024;
	localparam logic [11:0] SIN_C = 12'd2320;

	// control traveling with the quotient from the divider
	typedef struct packed {
		logic valid;
		logic black;
	} ecp_tag_t;
endpackage

[hw/rtl/ecp_if.sv]
// Interfaces: input item channel and pixel result channel
`timescale 1ns / 1ps
interface ecp_in_if;
	logic valid;
	logic ready;
	logic [ecp_pkg::CNT_W-1:0] iter_count;
	modport source (output valid, output iter_count, input ready);
	modport sink (input valid, input iter_count, output ready);
endinterface

interface ecp_out_if;
	logic valid;
	logic ready;
	logic [ecp_pkg::CH_W-1:0] red;
	logic [ecp_pkg::CH_W-1:0] green;
	logic [ecp_pkg::CH_W-1:0] blue;
	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

[hw/rtl/ecp_div.sv]
// Divider: pipelined restoring division, one quotient bit per stage
`timescale 1ns / 1ps
module ecp_div #(
	parameter int FB = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [ecp_pkg::CNT_W-1:0] count,
	input  logic [ecp_pkg::CNT_W-1:0] max_count,
	output ecp_pkg::ecp_tag_t tag,
	output logic [FB-1:0] quot
);
	logic [FB-1:0] v_s;
	logic blk_s [FB];
	logic [ecp_pkg::CNT_W-1:0] rem_s [FB];
	logic [FB-1:0] q_s [FB];

	genvar k;
	for (k = 0; k < FB; k++) begin : g_step
		logic [ecp_pkg::CNT_W-1:0] rp;
		logic [FB-1:0] qp;
		logic vp, bp, ge;
		logic [ecp_pkg::CNT_W:0] dbl;
		logic [ecp_pkg::CNT_W:0] dif;
		if (k == 0) begin : g_first
			assign rp = count;
			assign qp = '0;
			assign vp = in_valid;
			assign bp = (count >= max_count);
		end else begin : g_next
			assign rp = rem_s[k-1];
			assign qp = q_s[k-1];
			assign vp = v_s[k-1];
			assign bp = blk_s[k-1];
		end
		assign dbl = {rp, 1'b0};
		assign ge = (dbl >= {1'b0, max_count});
		assign dif = dbl - {1'b0, max_count};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= vp;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? dif[ecp_pkg::CNT_W-1:0] : dbl[ecp_pkg::CNT_W-1:0];
				q_s[k] <= {qp[FB-2:0], ge};
				blk_s[k] <= bp;
			end
		end
	end

	assign tag.valid = v_s[FB-1];
	assign tag.black = blk_s[FB-1];
	assign quot = q_s[FB-1];
endmodule

[hw/rtl/ecp_sine.sv]
// Sine channel: phase, quarter-wave fold and polynomial, six register stages
`timescale 1ns / 1ps
module ecp_sine #(
	parameter int FB = 16
) (
	input  logic clk,
	input  logic en,
	input  logic [FB+4:0] angle,
	output logic [ecp_pkg::CH_W-1:0] ch
);
	localparam int PW = FB + 35;

	logic [PW-1:0] prod;
	logic [15:0] phase_s1;

	logic [14:0] u, u_s2, u_s3, u_s4;
	logic [29:0] uu;
	logic [14:0] u2_s2, u2_s3;
	logic neg_s2, neg_s3, neg_s4, neg_s5;

	logic [26:0] p3;
	logic [14:0] t2_s3;
	logic [29:0] p4;
	logic [15:0] t4_s4;
	logic [30:0] p5;
	logic [15:0] s_s5;
	logic [23:0] p6;

	assign prod = PW'(angle) * PW'(ecp_pkg::PHASE_SCALE);
	assign u = phase_s1[14] ? 15'(15'd16384 - {1'b0, phase_s1[13:0]})
		: {1'b0, phase_s1[13:0]};
	assign uu = 30'(u) * 30'(u);
	assign p3 = 27'(ecp_pkg::SIN_C) * 27'(u2_s2);
	assign p4 = 30'(t2_s3) * 30'(u2_s3);
	assign p5 = 31'(t4_s4) * 31'(u_s4);
	assign p6 = 24'(s_s5) * 24'd255;

	always_ff @(posedge clk) begin
		if (en) begin
			phase_s1 <= prod[FB+31:FB+16];
			u_s2 <= u;
			u2_s2 <= uu[28:14];
			neg_s2 <= phase_s1[15];
			t2_s3 <= 15'(ecp_pkg::SIN_B - {2'b00, p3[26:14]});
			u_s3 <= u_s2;
			u2_s3 <= u2_s2;
			neg_s3 <= neg_s2;
			t4_s4 <= ecp_pkg::SIN_A - {1'b0, p4[28:14]};
			u_s4 <= u_s3;
			neg_s4 <= neg_s3;
			// saturate at 1.0 in Q1.15
			s_s5 <= (p5[30:14] > 17'd32768) ? 16'd32768 : p5[29:14];
			neg_s5 <= neg_s4;
			ch <= neg_s5 ? '0 : p6[22:15];
		end
	end
endmodule

[hw/rtl/ecp_color.sv]
// Palette: seven-stage color pipeline fed by the quotient
`timescale 1ns / 1ps
module ecp_color #(
	parameter int FB = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  ecp_pkg::ecp_tag_t tag,
	input  logic [FB-1:0] t,
	input  logic [ecp_pkg::MODE_W-1:0] mode,
	output logic out_valid,
	output logic [ecp_pkg::CH_W-1:0] red,
	output logic [ecp_pkg::CH_W-1:0] green,
	output logic [ecp_pkg::CH_W-1:0] blue
);
	localparam int NS = 6;

	logic [NS:0] v_s;
	logic blk_d [NS];
	logic [ecp_pkg::MODE_W-1:0] mode_d [NS];

	logic [FB+7:0] pr, pg;
	logic [FB+1:0] nb;
	logic [FB+9:0] pb;
	logic [FB:0] om;
	logic [2*FB:0] gp;
	logic [2*FB+10:0] gm;

	logic [7:0] r_s1, gy_s1;
	logic [8:0] b_s1;
	logic [2*FB:0] gp_s1;
	logic [3*ecp_pkg::CH_W-1:0] pal_d [2:NS];
	logic [3*ecp_pkg::CH_W-1:0] pal_2;
	logic [7:0] g2, b2;

	logic [FB+4:0] ang_r, ang_g, ang_b;
	logic [ecp_pkg::CH_W-1:0] sr, sg, sb;

	assign pr = (FB+8)'(t) * (FB+8)'(153);
	assign pg = (FB+8)'(t) * (FB+8)'(255);
	assign nb = {2'b10, {FB{1'b0}}} - (FB+2)'(t);
	assign pb = (FB+10)'(nb) * (FB+10)'(255);
	assign om = {1'b1, {FB{1'b0}}} - (FB+1)'(t);
	assign gp = (2*FB+1)'(t) * (2*FB+1)'(om);
	assign gm = (2*FB+11)'(gp_s1) * (2*FB+11)'(1020);

	assign g2 = (gm[2*FB+10:2*FB] > 11'd255) ? 8'd255 : gm[2*FB+7:2*FB];
	assign b2 = (b_s1 > 9'd255) ? 8'd255 : b_s1[7:0];
	assign pal_2 = (mode_d[0] == ecp_pkg::MODE_BASIC) ? {r_s1, g2, b2}
		: {gy_s1, gy_s1, gy_s1};

	// sine angles 16t, 13t + 2, 17t + 4
	assign ang_r = (FB+5)'(t) << 4;
	assign ang_g = (FB+5)'(t) * (FB+5)'(13) + {4'b0001, {(FB+1){1'b0}}};
	assign ang_b = (FB+5)'(t) * (FB+5)'(17) + {3'b001, {(FB+2){1'b0}}};

	ecp_sine #(.FB(FB)) u_sin_r (.clk(clk), .en(en), .angle(ang_r), .ch(sr));
	ecp_sine #(.FB(FB)) u_sin_g (.clk(clk), .en(en), .angle(ang_g), .ch(sg));
	ecp_sine #(.FB(FB)) u_sin_b (.clk(clk), .en(en), .angle(ang_b), .ch(sb));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[NS-1:0], tag.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			blk_d[0] <= tag.black;
			mode_d[0] <= mode;
			for (int i = 1; i < NS; i++) begin
				blk_d[i] <= blk_d[i-1];
				mode_d[i] <= mode_d[i-1];
			end
			r_s1 <= 8'(pr[FB+7:FB+1]);
			gy_s1 <= pg[FB+7:FB];
			b_s1 <= pb[FB+9:FB+1];
			gp_s1 <= gp;
			pal_d[2] <= pal_2;
			for (int i = 3; i <= NS; i++) begin
				pal_d[i] <= pal_d[i-1];
			end
			if (blk_d[NS-1]) begin
				{red, green, blue} <= '0;
			end else if (mode_d[NS-1] == ecp_pkg::MODE_SINE) begin
				{red, green, blue} <= {sr, sg, sb};
			end else begin
				{red, green, blue} <= pal_d[NS];
			end
		end
	end

	assign out_valid = v_s[NS];
endmodule

[hw/rtl/escape_count_palette.sv]
// Top level: escape count to RGB pixel color
`timescale 1ns / 1ps
// Usage:
//  pix_in carries one escape count per item (valid/ready); pix_out returns
//  one RGB pixel per item in the same order. Config is a plain write port:
//  cfg_we with cfg_index 0 writes max_count, index 1 writes palette_mode.
//  Write config only while no item is in flight.
// Pipeline: FRACTION_BITS divider stages, one quotient bit each, then a
//  seven-stage palette whose longest path is the sine polynomial.
// Throughput: one item per cycle while pix_out is not held off, set by the
//  fully pipelined divider and the three sine units running side by side.
// Reset: pipeline valids and the skid entry clear; max_count goes to 100,
//  palette_mode to basic.
// Stall: when pix_out is held off, the finished pixel drops into a one-entry
//  skid register and the pipeline freezes the cycle after; pix_in.ready
//  falls only while the skid entry is full. Nothing is lost or repeated.
module escape_count_palette #(
	parameter int FRACTION_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	ecp_in_if.sink pix_in,
	ecp_out_if.source pix_out,
	input  logic cfg_we,
	input  logic [ecp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ecp_pkg::CFG_DATA_W-1:0] cfg_data
);
	logic [ecp_pkg::CNT_W-1:0] max_count_q;
	logic [ecp_pkg::MODE_W-1:0] mode_q;

	logic en;
	ecp_pkg::ecp_tag_t div_tag;
	logic [FRACTION_BITS-1:0] quot;

	logic c_valid;
	logic [ecp_pkg::CH_W-1:0] c_red, c_green, c_blue;

	logic skid_full_q;
	logic [3*ecp_pkg::CH_W-1:0] skid_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_count_q <= ecp_pkg::MAX_COUNT_RST;
			mode_q <= ecp_pkg::MODE_BASIC;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ecp_pkg::CFG_MAX_COUNT: max_count_q <= cfg_data;
				ecp_pkg::CFG_PALETTE_MODE: mode_q <= cfg_data[ecp_pkg::MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// whole pipeline advances unless the skid entry holds a pixel
	assign en = !skid_full_q;
	assign pix_in.ready = en;

	ecp_div #(.FB(FRACTION_BITS)) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(pix_in.valid),
		.count(pix_in.iter_count),
		.max_count(max_count_q),
		.tag(div_tag),
		.quot(quot)
	);

	ecp_color #(.FB(FRACTION_BITS)) u_color (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.tag(div_tag),
		.t(quot),
		.mode(mode_q),
		.out_valid(c_valid),
		.red(c_red),
		.green(c_green),
		.blue(c_blue)
	);

	// skid: catch the last stage's pixel when the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (pix_out.ready) begin
				skid_full_q <= 1'b0;
			end
		end else if (c_valid && !pix_out.ready) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_full_q && c_valid && !pix_out.ready) begin
			skid_q <= {c_red, c_green, c_blue};
		end
	end

	assign pix_out.valid = skid_full_q || c_valid;
	assign {pix_out.red, pix_out.green, pix_out.blue} = skid_full_q ? skid_q
		: {c_red, c_green, c_blue};
endmodule

[hw/rtl/ecp_check.sv]
// Checker: port-level assertions on the escape count palette, with its bind
`timescale 1ns / 1ps
`include "escape_count_palette_assert.svh"
module ecp_check (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue
);
	`ECP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "pixel dropped while stalled")
	`ECP_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable({red, green, blue}), "stalled pixel changed")
	`ECP_ASSERT_NOW(a_ready_low, !in_ready, out_valid, "input held off with no pixel pending")
	`ECP_ASSERT_NOW(a_ready_fall, $fell(in_ready), $past(out_valid && !out_ready), "input held off without stall")
endmodule

bind escape_count_palette ecp_check u_ecp_check (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(pix_in.ready),
	.out_valid(pix_out.valid),
	.out_ready(pix_out.ready),
	.red(pix_out.red),
	.green(pix_out.green),
	.blue(pix_out.blue)
);

[tb/sv/ecp_pixel_checker.sv]
// Checker: watches both channels and the config port, predicts and compares pixels
`timescale 1ns / 1ps
module ecp_pixel_checker #(
	parameter int FRACTION_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	ecp_in_if in_ch,
	ecp_out_if out_ch,
	input  logic cfg_we,
	input  logic [ecp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ecp_pkg::CFG_DATA_W-1:0] cfg_data,
	output int pixels_pending,
	output int fail_count
);
	localparam int F = FRACTION_BITS;

	typedef struct packed {
		logic [ecp_pkg::CH_W-1:0] red;
		logic [ecp_pkg::CH_W-1:0] green;
		logic [ecp_pkg::CH_W-1:0] blue;
	} rgb_t;

	logic [ecp_pkg::CNT_W-1:0] limit_q;
	logic [ecp_pkg::MODE_W-1:0] mode_q;
	rgb_t expected_pixels[$];
	int mismatches;

	function automatic longint unsigned sat255(input longint unsigned v);
		return (v > 255) ? 255 : v;
	endfunction

	// 255*sin(angle) with quarter-wave folding, negative half clamps to 0
	function automatic longint unsigned sine_level(input longint unsigned angle);
		longint unsigned phase, quad, u, u2, s;
		phase = ((angle * 64'd683565276) >> (F + 16)) & 64'hFFFF;
		quad = phase >> 14;
		u = phase & 64'h3FFF;
		if (quad >= 2)
			return 0;
		if (quad == 1)
			u = 16384 - u;
		u2 = (u * u) >> 14;
		s = 21024 - ((2320 * u2) >> 14);
		s = 51472 - ((s * u2) >> 14);
		s = (s * u) >> 14;
		if (s > 32768)
			s = 32768;
		return sat255((255 * s) >> 15);
	endfunction

	function automatic rgb_t color_of_count(input logic [ecp_pkg::CNT_W-1:0] cnt,
			input logic [ecp_pkg::CNT_W-1:0] lim,
			input logic [ecp_pkg::MODE_W-1:0] mode);
		longint unsigned one, t, r, g, b;
		rgb_t px;
		one = 64'd1 << F;
		if (cnt >= lim)
			return '0;
		t = (longint'(cnt) << F) / lim;
		case (mode)
			ecp_pkg::MODE_BASIC: begin
				r = (153 * t) >> (F + 1);
				g = (1020 * t * (one - t)) >> (2 * F);
				b = (255 * (2 * one - t)) >> (F + 1);
			end
			ecp_pkg::MODE_SINE: begin
				r = sine_level(16 * t);
				g = sine_level(13 * t + 2 * one);
				b = sine_level(17 * t + 4 * one);
			end
			default: begin
				r = (255 * t) >> F;
				g = r;
				b = r;
			end
		endcase
		px.red = 8'(sat255(r));
		px.green = 8'(sat255(g));
		px.blue = 8'(sat255(b));
		return px;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rgb_t got, want;
		if (!arst_n) begin
			limit_q <= ecp_pkg::MAX_COUNT_RST;
			mode_q <= ecp_pkg::MODE_BASIC;
			expected_pixels.delete();
			mismatches = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == ecp_pkg::CFG_MAX_COUNT)
					limit_q <= cfg_data;
				else if (cfg_index == ecp_pkg::CFG_PALETTE_MODE)
					mode_q <= cfg_data[ecp_pkg::MODE_W-1:0];
			end
			if (in_ch.valid && in_ch.ready)
				expected_pixels.push_back(color_of_count(in_ch.iter_count, limit_q, mode_q));
			if (out_ch.valid && out_ch.ready) begin
				got = '{out_ch.red, out_ch.green, out_ch.blue};
				if (expected_pixels.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected pixel r=%0d g=%0d b=%0d",
							got.red, got.green, got.blue);
				end else begin
					want = expected_pixels.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("pixel mismatch: exp r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
								want.red, want.green, want.blue,
								got.red, got.green, got.blue);
					end
				end
			end
		end
	end

	assign pixels_pending = expected_pixels.size();
	assign fail_count = mismatches;
endmodule

[tb/sv/tb_top.sv]
// Testbench top: clock, reset, stimulus and final verdict for escape_count_palette
`timescale 1ns / 1ps
module tb_top;
	localparam int FRACTION_BITS = 16;
	// covers the divider and palette pipeline plus skid entry, with margin
	localparam int DRAIN_CYCLES = FRACTION_BITS + 20;
	localparam int CYCLE_LIMIT = 400000;
	// index past the register list; writes there are ignored
	localparam logic [ecp_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [ecp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ecp_pkg::CFG_DATA_W-1:0] cfg_data;
	int pixels_pending;
	int fail_count;
	int cycles;
	int send_idle_pct;
	int recv_idle_pct;
	logic [ecp_pkg::CNT_W-1:0] cur_limit;

	ecp_in_if in_ch();
	ecp_out_if out_ch();

	escape_count_palette #(.FRACTION_BITS(FRACTION_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix_in(in_ch.sink),
		.pix_out(out_ch.source),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	ecp_pixel_checker #(.FRACTION_BITS(FRACTION_BITS)) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pixels_pending(pixels_pending),
		.fail_count(fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog: generous bound on the whole run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Receiver: ready drops at random per the current idle rate
	always @(posedge clk) begin
		if (arst_n)
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Register write with a gap before the next, so we never toggles within a step
	task automatic write_reg(input logic [ecp_pkg::CFG_IDX_W-1:0] idx,
			input logic [ecp_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == ecp_pkg::CFG_MAX_COUNT)
			cur_limit = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every pixel is back and the pipe has flushed
	task automatic drain_pipe();
		in_ch.valid <= 1'b0;
		while (pixels_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Offer one count; ready is sampled at the falling edge to avoid races
	task automatic send_count(input logic [ecp_pkg::CNT_W-1:0] c);
		logic rdy;
		if ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.iter_count <= c;
		forever begin
			@(negedge clk);
			rdy = in_ch.ready;
			@(posedge clk);
			if (rdy)
				break;
		end
	endtask

	// Mostly in-range counts, some at or above the limit, some unrestricted
	function automatic logic [ecp_pkg::CNT_W-1:0] pick_count();
		int r;
		r = $urandom_range(99);
		if (r < 70 && cur_limit != 0)
			return 16'($urandom_range(cur_limit - 16'd1));
		if (r < 85)
			return 16'($urandom_range(65535, cur_limit));
		return 16'($urandom);
	endfunction

	initial begin
		cycles = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = ecp_pkg::CFG_MAX_COUNT;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.iter_count = '0;
		out_ch.ready = 1'b0;
		send_idle_pct = 27;
		recv_idle_pct = 49;
		cur_limit = ecp_pkg::MAX_COUNT_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset config, edges around the limit
		send_count(16'd0);
		send_count(16'd1);
		send_count(16'd50);
		send_count(16'd99);
		send_count(16'd100);
		send_count(16'hFFFF);
		drain_pipe();

		// every palette (mode 3 falls back to grey) at the widest limit
		write_reg(ecp_pkg::CFG_MAX_COUNT, 16'hFFFF);
		for (int m = 0; m < 4; m++) begin
			write_reg(ecp_pkg::CFG_PALETTE_MODE, m[ecp_pkg::CFG_DATA_W-1:0]);
			send_count(16'd0);
			send_count(16'h8000);
			send_count(16'hFFFE);
			send_count(16'hFFFF);
			drain_pipe();
		end

		// zero limit: everything black; write to unused index is ignored
		write_reg(ecp_pkg::CFG_MAX_COUNT, 16'd0);
		write_reg(CFG_UNUSED, 16'hFFFF);
		send_count(16'd0);
		send_count(16'd7);
		drain_pipe();
		write_reg(ecp_pkg::CFG_MAX_COUNT, 16'd1);
		send_count(16'd0);
		send_count(16'd1);
		drain_pipe();

		// random segments: idle pattern changes every three segments
		for (int seg = 0; seg < 9; seg++) begin
			if (seg == 3) begin
				send_idle_pct = 49;
				recv_idle_pct = 27;
			end else if (seg == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (seg % 3)
				0: write_reg(ecp_pkg::CFG_MAX_COUNT, 16'($urandom_range(300, 2)));
				1: write_reg(ecp_pkg::CFG_MAX_COUNT, (seg % 2) ? 16'hFFFF : 16'd1);
				default: write_reg(ecp_pkg::CFG_MAX_COUNT, 16'($urandom_range(65535, 1)));
			endcase
			write_reg(ecp_pkg::CFG_PALETTE_MODE, 16'(seg % 4));
			for (int k = 0; k < 110; k++)
				send_count(pick_count());
			drain_pipe();
		end

		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
